@@ sv/lip_pkg.sv @@
// Shared types and codes for the line intersection block.
`default_nettype none
package lip_pkg;

    localparam int LIMIT_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CROSS_W = 32;

    typedef enum logic [1:0] {
        ST_FOUND    = 2'd0,
        ST_PARALLEL = 2'd1,
        ST_OUTSIDE  = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOUNDS = 2'd0,
        CFG_XLIM   = 2'd1,
        CFG_YLIM   = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic par;
        logic neg_x;
        logic neg_y;
    } lip_flags_t;

endpackage
`default_nettype wire

@@ sv/lip_front.sv @@
// Front pipeline: differences, determinant, numerators, signs and magnitudes.
`default_nettype none
module lip_front #(
    parameter int C = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  v_in,
    input  wire logic signed [C-1:0]   x1,
    input  wire logic signed [C-1:0]   y1,
    input  wire logic signed [C-1:0]   x2,
    input  wire logic signed [C-1:0]   y2,
    input  wire logic signed [C-1:0]   x3,
    input  wire logic signed [C-1:0]   y3,
    input  wire logic signed [C-1:0]   x4,
    input  wire logic signed [C-1:0]   y4,
    output logic                       v_out,
    output lip_pkg::lip_flags_t        flags_out,
    output logic [2*C+3:0]             dm_out,
    output logic [3*C+2:0]             nx_mag_out,
    output logic [3*C+2:0]             ny_mag_out
);
    import lip_pkg::*;

    localparam int DF = C + 1;
    localparam int PC = 2 * C;
    localparam int PD = 2 * C + 2;
    localparam int DS = 2 * C + 4;
    localparam int PP = 2 * C + 1;
    localparam int M  = PP + DF;
    localparam int NS = 3 * C + 3;

    logic signed [DF-1:0] dx12, dy12, dx34, dy34;

    logic               va_reg;
    logic signed [PC-1:0] pa_reg, pb_reg, qa_reg, qb_reg;
    logic signed [PD-1:0] da_reg, db_reg;
    logic signed [DF-1:0] dx12a_reg, dy12a_reg, dx34a_reg, dy34a_reg;

    logic               vb_reg;
    logic signed [DS-1:0] d_b_reg;
    logic signed [PP-1:0] p_reg, q_reg;
    logic signed [DF-1:0] dx12b_reg, dy12b_reg, dx34b_reg, dy34b_reg;

    logic               vc_reg;
    logic signed [DS-1:0] d_c_reg;
    logic signed [M-1:0]  m1_reg, m2_reg, m3_reg, m4_reg;

    logic signed [NS-1:0] nx, ny;
    logic signed [DS-1:0] d_neg;

    assign dx12 = DF'(x1) - DF'(x2);
    assign dy12 = DF'(y1) - DF'(y2);
    assign dx34 = DF'(x3) - DF'(x4);
    assign dy34 = DF'(y3) - DF'(y4);

    assign nx = NS'(m1_reg) - NS'(m2_reg);
    assign ny = NS'(m3_reg) - NS'(m4_reg);
    assign d_neg = -d_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            v_out  <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= v_in;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            v_out  <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg    <= x1 * y2;
            pb_reg    <= y1 * x2;
            qa_reg    <= x3 * y4;
            qb_reg    <= y3 * x4;
            da_reg    <= dx12 * dy34;
            db_reg    <= dy12 * dx34;
            dx12a_reg <= dx12;
            dy12a_reg <= dy12;
            dx34a_reg <= dx34;
            dy34a_reg <= dy34;

            d_b_reg   <= DS'(da_reg) - DS'(db_reg);
            p_reg     <= PP'(pa_reg) - PP'(pb_reg);
            q_reg     <= PP'(qa_reg) - PP'(qb_reg);
            dx12b_reg <= dx12a_reg;
            dy12b_reg <= dy12a_reg;
            dx34b_reg <= dx34a_reg;
            dy34b_reg <= dy34a_reg;

            d_c_reg   <= d_b_reg;
            m1_reg    <= p_reg * dx34b_reg;
            m2_reg    <= dx12b_reg * q_reg;
            m3_reg    <= p_reg * dy34b_reg;
            m4_reg    <= dy12b_reg * q_reg;

            flags_out.par   <= (d_c_reg == '0);
            flags_out.neg_x <= nx[NS-1] ^ d_c_reg[DS-1];
            flags_out.neg_y <= ny[NS-1] ^ d_c_reg[DS-1];
            dm_out          <= d_c_reg[DS-1] ? d_neg : d_c_reg;
            nx_mag_out      <= nx[NS-1] ? -nx : nx;
            ny_mag_out      <= ny[NS-1] ? -ny : ny;
        end
    end

endmodule
`default_nettype wire

@@ sv/lip_div_cell.sv @@
// One restoring-division cell: one quotient bit for x and for y.
`default_nettype none
module lip_div_cell #(
    parameter int DW = 36,
    parameter int NW = 51
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 v_in,
    input  wire lip_pkg::lip_flags_t  flags_in,
    input  wire logic [DW-1:0]        dm_in,
    input  wire logic [DW-1:0]        rem_x_in,
    input  wire logic [NW-1:0]        nq_x_in,
    input  wire logic [DW-1:0]        rem_y_in,
    input  wire logic [NW-1:0]        nq_y_in,
    output logic                      v_out,
    output lip_pkg::lip_flags_t       flags_out,
    output logic [DW-1:0]             dm_out,
    output logic [DW-1:0]             rem_x_out,
    output logic [NW-1:0]             nq_x_out,
    output logic [DW-1:0]             rem_y_out,
    output logic [NW-1:0]             nq_y_out
);
    import lip_pkg::*;

    logic [DW:0] tx, ty, sx, sy;
    logic        gx, gy;

    assign tx = {rem_x_in, nq_x_in[NW-1]};
    assign ty = {rem_y_in, nq_y_in[NW-1]};
    assign sx = tx - {1'b0, dm_in};
    assign sy = ty - {1'b0, dm_in};
    assign gx = (tx >= {1'b0, dm_in});
    assign gy = (ty >= {1'b0, dm_in});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_out <= 1'b0;
        else if (en)
            v_out <= v_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flags_out <= flags_in;
            dm_out    <= dm_in;
            rem_x_out <= gx ? sx[DW-1:0] : tx[DW-1:0];
            rem_y_out <= gy ? sy[DW-1:0] : ty[DW-1:0];
            nq_x_out  <= {nq_x_in[NW-2:0], gx};
            nq_y_out  <= {nq_y_in[NW-2:0], gy};
        end
    end

endmodule
`default_nettype wire

@@ sv/lip_back.sv @@
// Back pipeline: floor correction, saturation, window test and output register.
`default_nettype none
module lip_back #(
    parameter int DW = 36,
    parameter int NW = 51
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          v_in,
    input  wire lip_pkg::lip_flags_t           flags_in,
    input  wire logic [DW-1:0]                 rem_x,
    input  wire logic [NW-1:0]                 qx,
    input  wire logic [DW-1:0]                 rem_y,
    input  wire logic [NW-1:0]                 qy,
    input  wire logic                          bounds_en,
    input  wire logic [lip_pkg::LIMIT_W-1:0]   x_lim,
    input  wire logic [lip_pkg::LIMIT_W-1:0]   y_lim,
    output logic                               v_out,
    output lip_pkg::status_t                   status_out,
    output logic signed [lip_pkg::CROSS_W-1:0] cx_out,
    output logic signed [lip_pkg::CROSS_W-1:0] cy_out
);
    import lip_pkg::*;

    localparam int W = (NW + 1 > CROSS_W + 1) ? NW + 1 : CROSS_W + 1;

    function automatic logic [CROSS_W-1:0] sat_q(
        input logic [NW-1:0] q,
        input logic          rnz,
        input logic          neg
    );
        logic [W-1:0] qe;
        logic [W-1:0] qn;
        qe = W'(q);
        qn = qe + W'(rnz);
        if (neg)
        begin
            if (qn > (W'(1) << (CROSS_W - 1)))
                sat_q = {1'b1, {(CROSS_W-1){1'b0}}};
            else
                sat_q = -qn[CROSS_W-1:0];
        end
        else
        begin
            if (qe > ((W'(1) << (CROSS_W - 1)) - W'(1)))
                sat_q = {1'b0, {(CROSS_W-1){1'b1}}};
            else
                sat_q = qe[CROSS_W-1:0];
        end
        return sat_q;
    endfunction

    logic                      ve_reg;
    logic                      par_reg;
    logic signed [CROSS_W-1:0] cx_reg, cy_reg;
    logic                      outside;

    assign outside = bounds_en &&
                     (cx_reg[CROSS_W-1] || cy_reg[CROSS_W-1] ||
                      (cx_reg >= $signed(CROSS_W'(x_lim))) ||
                      (cy_reg >= $signed(CROSS_W'(y_lim))));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ve_reg <= 1'b0;
            v_out  <= 1'b0;
        end
        else if (en)
        begin
            ve_reg <= v_in;
            v_out  <= ve_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            par_reg <= flags_in.par;
            cx_reg  <= sat_q(qx, (rem_x != '0), flags_in.neg_x);
            cy_reg  <= sat_q(qy, (rem_y != '0), flags_in.neg_y);
            if (par_reg)
            begin
                status_out <= ST_PARALLEL;
                cx_out     <= '0;
                cy_out     <= '0;
            end
            else if (outside)
            begin
                status_out <= ST_OUTSIDE;
                cx_out     <= '0;
                cy_out     <= '0;
            end
            else
            begin
                status_out <= ST_FOUND;
                cx_out     <= cx_reg;
                cy_out     <= cy_reg;
            end
        end
    end

endmodule
`default_nettype wire

@@ sv/line_intersection_point.sv @@
// Top level of the two-line intersection block.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------
//  in       | input     | in_valid/in_stall  | first_*, second_* end points
//  out      | output    | out_valid/out_stall| status, cross_x, cross_y
//  cfg      | input     | cfg_write          | cfg_index, cfg_data
//
//  One transaction per cycle unless a valid output is stalled; the pipeline is
//  the chain of division cells (one quotient bit per cell) plus four front and
//  two back stages. Reset empties the pipeline and loads the register defaults.
//  A stalled output transaction freezes the whole pipeline, bubbles included.
`default_nettype none
module line_intersection_point #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic signed [COORD_BITS-1:0]     first_start_x,
    input  wire logic signed [COORD_BITS-1:0]     first_start_y,
    input  wire logic signed [COORD_BITS-1:0]     first_end_x,
    input  wire logic signed [COORD_BITS-1:0]     first_end_y,
    input  wire logic signed [COORD_BITS-1:0]     second_start_x,
    input  wire logic signed [COORD_BITS-1:0]     second_start_y,
    input  wire logic signed [COORD_BITS-1:0]     second_end_x,
    input  wire logic signed [COORD_BITS-1:0]     second_end_y,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output lip_pkg::status_t                      status,
    output logic signed [lip_pkg::CROSS_W-1:0]    cross_x,
    output logic signed [lip_pkg::CROSS_W-1:0]    cross_y,
    input  wire logic                             cfg_write,
    input  wire logic [lip_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [lip_pkg::LIMIT_W-1:0]      cfg_data
);
    import lip_pkg::*;

    localparam int DW = 2 * COORD_BITS + 4;
    localparam int NW = 3 * COORD_BITS + 3;

    logic                en;
    logic                bounds_en_reg;
    logic [LIMIT_W-1:0]  x_lim_reg, y_lim_reg;

    logic                v_ch     [NW+1];
    lip_flags_t          flags_ch [NW+1];
    logic [DW-1:0]       dm_ch    [NW+1];
    logic [DW-1:0]       remx_ch  [NW+1];
    logic [NW-1:0]       nqx_ch   [NW+1];
    logic [DW-1:0]       remy_ch  [NW+1];
    logic [NW-1:0]       nqy_ch   [NW+1];

    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bounds_en_reg <= 1'b1;
            x_lim_reg     <= LIMIT_W'(1024);
            y_lim_reg     <= LIMIT_W'(1024);
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_BOUNDS: bounds_en_reg <= cfg_data[0];
                CFG_XLIM:   x_lim_reg     <= cfg_data;
                CFG_YLIM:   y_lim_reg     <= cfg_data;
                default:    ;
            endcase
        end
    end

    assign remx_ch[0] = '0;
    assign remy_ch[0] = '0;

    lip_front #(
        .C (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .v_in       (in_valid),
        .x1         (first_start_x),
        .y1         (first_start_y),
        .x2         (first_end_x),
        .y2         (first_end_y),
        .x3         (second_start_x),
        .y3         (second_start_y),
        .x4         (second_end_x),
        .y4         (second_end_y),
        .v_out      (v_ch[0]),
        .flags_out  (flags_ch[0]),
        .dm_out     (dm_ch[0]),
        .nx_mag_out (nqx_ch[0]),
        .ny_mag_out (nqy_ch[0])
    );

    for (genvar i = 0; i < NW; i++)
    begin : g_cell
        lip_div_cell #(
            .DW (DW),
            .NW (NW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .v_in      (v_ch[i]),
            .flags_in  (flags_ch[i]),
            .dm_in     (dm_ch[i]),
            .rem_x_in  (remx_ch[i]),
            .nq_x_in   (nqx_ch[i]),
            .rem_y_in  (remy_ch[i]),
            .nq_y_in   (nqy_ch[i]),
            .v_out     (v_ch[i+1]),
            .flags_out (flags_ch[i+1]),
            .dm_out    (dm_ch[i+1]),
            .rem_x_out (remx_ch[i+1]),
            .nq_x_out  (nqx_ch[i+1]),
            .rem_y_out (remy_ch[i+1]),
            .nq_y_out  (nqy_ch[i+1])
        );
    end

    lip_back #(
        .DW (DW),
        .NW (NW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .v_in       (v_ch[NW]),
        .flags_in   (flags_ch[NW]),
        .rem_x      (remx_ch[NW]),
        .qx         (nqx_ch[NW]),
        .rem_y      (remy_ch[NW]),
        .qy         (nqy_ch[NW]),
        .bounds_en  (bounds_en_reg),
        .x_lim      (x_lim_reg),
        .y_lim      (y_lim_reg),
        .v_out      (out_valid),
        .status_out (status),
        .cx_out     (cross_x),
        .cy_out     (cross_y)
    );

    a_par_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_FOUND) |-> (cross_x == '0) && (cross_y == '0))
        else $error("non-found transaction carries a nonzero point");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_FOUND) || (status == ST_PARALLEL) ||
                      (status == ST_OUTSIDE))
        else $error("undefined status code");

    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a blocked output");

    a_window: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FOUND) && bounds_en_reg &&
        $stable(x_lim_reg) |-> !cross_x[lip_pkg::CROSS_W-1])
        else $error("accepted point has negative x under window check");

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
// Testbench for line_intersection_point: directed and random line pairs checked against a predictor.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import lip_pkg::*;

    localparam int CW = 16;
    localparam int LATENCY = 3 * CW + 9;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        status_t         st;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
    } crossing_t;

    class crossing_scoreboard;
        logic       bounds_on;
        logic [15:0] xlim;
        logic [15:0] ylim;
        crossing_t  pending[$];
        int         mismatches;
        int         checked;
        int         parallel_seen;
        int         outside_seen;

        function new();
            bounds_on = 1'b1;
            xlim = 16'd1024;
            ylim = 16'd1024;
            mismatches = 0;
            checked = 0;
            parallel_seen = 0;
            outside_seen = 0;
        endfunction

        function longint floor_sat(logic signed [127:0] num, logic signed [127:0] den);
            logic signed [127:0] q;
            logic signed [127:0] r;
            q = num / den;
            r = num % den;
            if (r != 0 && ((r < 0) != (den < 0)))
                q = q - 1;
            if (q > 128'sd2147483647)
                return 64'sd2147483647;
            if (q < -128'sd2147483648)
                return -64'sd2147483648;
            return longint'(q);
        endfunction

        function void note_pair(logic signed [CW-1:0] c[8]);
            logic signed [127:0] x1, y1, x2, y2, x3, y3, x4, y4;
            logic signed [127:0] dx12, dy12, dx34, dy34, d, p, q;
            longint fx, fy;
            crossing_t e;
            x1 = c[0]; y1 = c[1]; x2 = c[2]; y2 = c[3];
            x3 = c[4]; y3 = c[5]; x4 = c[6]; y4 = c[7];
            dx12 = x1 - x2; dy12 = y1 - y2; dx34 = x3 - x4; dy34 = y3 - y4;
            d = dx12 * dy34 - dy12 * dx34;
            e.st = ST_PARALLEL;
            e.cx = '0;
            e.cy = '0;
            if (d != 0) begin
                p = x1 * y2 - y1 * x2;
                q = x3 * y4 - y3 * x4;
                fx = floor_sat(p * dx34 - dx12 * q, d);
                fy = floor_sat(p * dy34 - dy12 * q, d);
                if (bounds_on && (fx < 0 || fx >= longint'(xlim) ||
                                  fy < 0 || fy >= longint'(ylim))) begin
                    e.st = ST_OUTSIDE;
                end
                else begin
                    e.st = ST_FOUND;
                    e.cx = fx[31:0];
                    e.cy = fy[31:0];
                end
            end
            pending.push_back(e);
        endfunction

        function void check_result(status_t st, logic signed [31:0] cx,
                                   logic signed [31:0] cy);
            crossing_t e;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result status=%0d x=%0d y=%0d", st, cx, cy);
                return;
            end
            e = pending.pop_front();
            if (st == ST_PARALLEL) parallel_seen++;
            if (st == ST_OUTSIDE) outside_seen++;
            if (st !== e.st || cx !== e.cx || cy !== e.cy) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d expected %0d/%0d/%0d got %0d/%0d/%0d",
                             checked, e.st, e.cx, e.cy, st, cx, cy);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [CW-1:0] pt[8];
    logic out_valid;
    logic out_stall = 1'b0;
    status_t status;
    logic signed [31:0] cross_x;
    logic signed [31:0] cross_y;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [LIMIT_W-1:0] cfg_data = '0;

    crossing_scoreboard sb;
    longint cycles = 0;
    bit calm = 1'b0;
    int sent = 0;

    initial
    begin
        for (int i = 0; i < 8; i++)
            pt[i] = '0;
    end

    always #10 clk = ~clk;

    line_intersection_point #(.COORD_BITS(CW)) DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .first_start_x(pt[0]), .first_start_y(pt[1]),
        .first_end_x(pt[2]), .first_end_y(pt[3]),
        .second_start_x(pt[4]), .second_start_y(pt[5]),
        .second_end_x(pt[6]), .second_end_y(pt[7]),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .cross_x(cross_x), .cross_y(cross_y),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(status, cross_x, cross_y);
        out_stall <= calm ? 1'b0 : ($urandom_range(99) < 21);
    end

    task automatic send_pair(logic signed [CW-1:0] c[8]);
        while (!calm && $urandom_range(99) < 21) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        for (int i = 0; i < 8; i++)
            pt[i] <= c[i];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_pair(c);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_BOUNDS: sb.bounds_on = val[0];
            CFG_XLIM:   sb.xlim = val;
            CFG_YLIM:   sb.ylim = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_lines(int x1, int y1, int x2, int y2,
                              int x3, int y3, int x4, int y4);
        logic signed [CW-1:0] c[8];
        c[0] = CW'(x1); c[1] = CW'(y1); c[2] = CW'(x2); c[3] = CW'(y2);
        c[4] = CW'(x3); c[5] = CW'(y3); c[6] = CW'(x4); c[7] = CW'(y4);
        send_pair(c);
    endtask

    task automatic random_pairs(int n);
        logic signed [CW-1:0] c[8];
        int lim;
        for (int k = 0; k < n; k++) begin
            calm = (k >= n / 3 && k < n / 2);
            lim = ($urandom_range(3) == 0) ? 32767 : 600;
            for (int i = 0; i < 8; i++)
                c[i] = (lim == 32767) ? CW'($urandom) : CW'($urandom_range(1100) - 50);
            case ($urandom_range(9))
                0: begin
                    c[4] = CW'(c[0] + (c[2] - c[0]) * 2);
                    c[5] = CW'(c[1] + (c[3] - c[1]) * 2);
                end
                1: begin c[2] = c[0]; c[3] = c[1]; end
                2: begin c[6] = c[4] + c[2] - c[0]; c[7] = c[5] + c[3] - c[1]; end
                default: ;
            endcase
            send_pair(c);
        end
        calm = 1'b0;
    endtask

    initial
    begin
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_lines(0, 0, 10, 10, 0, 10, 10, 0);
        send_lines(0, 0, 10, 0, 0, 5, 10, 5);
        send_lines(3, 3, 3, 3, 0, 0, 5, 7);
        send_lines(-5, -5, 5, 5, -5, 5, 5, -5);
        send_lines(2000, 0, 2000, 10, 0, 3, 10, 3);
        send_lines(0, 0, 1, 0, -1, 0, -1, 1);
        send_lines(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
        send_lines(0, 0, 1, 1, 0, 1, 32767, 2);
        send_lines(-32768, 32767, 32767, -32767, 32767, 32767, -32768, -32766);
        send_lines(0, 0, 1, 3, 0, 1, 3, 1);
        send_lines(0, 0, 7, 3, 1, 0, 4, 2);
        send_lines(1023, 0, 1023, 9, 0, 1023, 9, 1023);
        send_lines(1024, 0, 1024, 9, 0, 5, 9, 5);
        drain();

        write_reg(CFG_BOUNDS, 16'd0);
        send_lines(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
        send_lines(0, 0, 1, 1, 0, 1, 32767, 2);
        send_lines(-32768, 32767, 32767, -32767, 32767, 32767, -32768, -32766);
        send_lines(0, 0, 1, 32767, 1, 0, 2, 32767);
        send_lines(-7, -7, -6, -6, -7, 5, 8, -10);
        random_pairs(150);
        drain();

        write_reg(CFG_BOUNDS, 16'hFFFF);
        write_reg(CFG_XLIM, 16'd0);
        write_reg(CFG_YLIM, 16'hFFFF);
        send_lines(0, 0, 10, 10, 0, 10, 10, 0);
        random_pairs(100);
        drain();

        write_reg(CFG_XLIM, 16'hFFFF);
        write_reg(CFG_YLIM, 16'd0);
        random_pairs(50);
        drain();

        write_reg(CFG_XLIM, 16'd300);
        write_reg(CFG_YLIM, 16'd700);
        random_pairs(150);
        drain();

        write_reg(CFG_XLIM, 16'd1024);
        write_reg(CFG_YLIM, 16'd1024);
        random_pairs(130);
        drain();

        $display("Covered %0d line pairs, %0d results (%0d parallel, %0d outside window)",
                 sent, sb.checked, sb.parallel_seen, sb.outside_seen);
        $display("Bounds check on and off; window limits swept from zero to full range");
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
sv/lip_pkg.sv
sv/lip_front.sv
sv/lip_div_cell.sv
sv/lip_back.sv
sv/line_intersection_point.sv
sim/testbench.sv
